// File: design/brf_pkg.sv
// shared types and constants for the byte ring fifo with line counter
package brf_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int SIZE_W    = 9;
  localparam int COUNT_W   = 8;

  localparam logic [SIZE_W-1:0] RING_SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] RING_SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] RING_SIZE_MAX   = SIZE_W'(MAX_SLOTS);
  localparam logic [7:0]        NEWLINE_BYTE    = 8'h0A;

  localparam logic FUNC_PUT    = 1'b0;
  localparam logic FUNC_GET    = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] put_byte;
  } item_t;

  typedef struct packed {
    logic               status;
    logic [7:0]         got_byte;
    logic [COUNT_W-1:0] line_count;
    logic [COUNT_W-1:0] fill_level;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // latch item and read the slot at the read index
    logic commit;  // apply the operation and load the result register
  } brf_cmd_t;

endpackage

// File: design/byte_ring_fifo_line_count.sv
// top level of the byte ring fifo with newline counter
// A byte fifo held in a 256-entry circular store, of which ring_size slots
// are in use (clamped to 2..256) and one is always left free, so capacity is
// ring_size - 1. Each item beat is a put (func 0) or a get (func 1); a full
// put or an empty get returns status 1 and changes nothing. Every item gives
// exactly one result beat carrying the status, the byte taken (zero unless a
// get succeeded), the count of newline bytes held and the fill level. A load
// step latches an item and reads the store at the read index (the read is
// registered); a commit step, held while a result stalls, applies it and
// loads the result register, so the next item can be taken while a result
// still waits. Writing ring_size empties the fifo; write it only while idle.
module byte_ring_fifo_line_count (
  input  logic             clk,
  input  logic             rst,
  // config write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [8:0]       cfg_data,
  // item channel
  input  logic             item_valid,
  output logic             item_stall,
  input  brf_pkg::item_t   item,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output brf_pkg::result_t result
);
  import brf_pkg::*;

  brf_cmd_t cmd;
  logic     cfg_we;

  // config beats are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  brf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  brf_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .result   (result)
  );

endmodule

// File: design/brf_ctrl.sv
// controller state machine: sequences load, commit and the result handshake
module brf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  output logic            result_valid,
  input  logic            result_stall,
  output brf_pkg::brf_cmd_t cmd
);
  import brf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd.load   = (state == ST_IDLE) && item_valid;
    cmd.commit = (state == ST_EXEC) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/brf_datapath.sv
// datapath: byte store, ring indices, counters and result register
module brf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_data,
  input  brf_pkg::item_t    item,
  input  brf_pkg::brf_cmd_t cmd,
  output brf_pkg::result_t  result
);
  import brf_pkg::*;

  logic [7:0]         byte_store [MAX_SLOTS];
  logic [7:0]         rd_data;
  item_t              item_hold;
  logic [SIZE_W-1:0]  ring_size;
  logic [SIZE_W-1:0]  size_eff;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx_next;
  logic [IDX_W-1:0]   wr_idx_next;
  logic [COUNT_W-1:0] line_count;
  logic [COUNT_W-1:0] fill_level;
  logic               full;
  logic               empty;
  logic               put_ok;
  logic               get_ok;
  logic [COUNT_W-1:0] line_count_next;
  logic [COUNT_W-1:0] fill_level_next;

  // clamp configured size into the legal range
  always_comb begin
    priority if (ring_size < RING_SIZE_MIN) size_eff = RING_SIZE_MIN;
    else if (ring_size > RING_SIZE_MAX)     size_eff = RING_SIZE_MAX;
    else                                    size_eff = ring_size;
  end

  always_comb begin
    if ((SIZE_W'(wr_idx) + SIZE_W'(1)) >= size_eff) wr_idx_next = '0;
    else                                            wr_idx_next = wr_idx + IDX_W'(1);
    if ((SIZE_W'(rd_idx) + SIZE_W'(1)) >= size_eff) rd_idx_next = '0;
    else                                            rd_idx_next = rd_idx + IDX_W'(1);
  end

  assign full   = (wr_idx_next == rd_idx);
  assign empty  = (rd_idx == wr_idx);
  assign put_ok = (item_hold.func == FUNC_PUT) && !full;
  assign get_ok = (item_hold.func == FUNC_GET) && !empty;

  always_comb begin
    line_count_next = line_count;
    fill_level_next = fill_level;
    if (put_ok) begin
      fill_level_next = fill_level + COUNT_W'(1);
      if (item_hold.put_byte == NEWLINE_BYTE) line_count_next = line_count + COUNT_W'(1);
    end else if (get_ok) begin
      fill_level_next = fill_level - COUNT_W'(1);
      if (rd_data == NEWLINE_BYTE) line_count_next = line_count - COUNT_W'(1);
    end
  end

  // store: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= byte_store[rd_idx];
    end
    if (cmd.commit && put_ok) begin
      byte_store[wr_idx] <= item_hold.put_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_hold <= item;
    if (cmd.commit) begin
      result.status     <= (put_ok || get_ok) ? STATUS_OK : STATUS_FAIL;
      result.got_byte   <= get_ok ? rd_data : 8'h00;
      result.line_count <= line_count_next;
      result.fill_level <= fill_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size  <= RING_SIZE_RESET;
      rd_idx     <= '0;
      wr_idx     <= '0;
      line_count <= '0;
      fill_level <= '0;
    end else if (cfg_we) begin
      ring_size  <= cfg_data;
      rd_idx     <= '0;
      wr_idx     <= '0;
      line_count <= '0;
      fill_level <= '0;
    end else if (cmd.commit) begin
      if (put_ok) wr_idx <= wr_idx_next;
      if (get_ok) rd_idx <= rd_idx_next;
      line_count <= line_count_next;
      fill_level <= fill_level_next;
    end
  end

endmodule
